[src/ipsc_pkg.sv]
// shared types, constants and register codes of the integer pid speed controller
package ipsc_pkg;

    localparam int DATA_W      = 32;
    localparam int DIVISOR_W   = 31;
    localparam int OPERAND_W   = DATA_W + 1;
    localparam int PRODUCT_W   = 2 * OPERAND_W;
    localparam int ACC_W       = PRODUCT_W + 1;
    localparam int DIVIDEND_W  = PRODUCT_W;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LOWER = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_UPPER = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_LOWER   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_UPPER   = 3'd7;

    localparam logic signed [DATA_W-1:0]    RST_PROP_GAIN   = 32'sd1;
    localparam logic signed [DATA_W-1:0]    RST_INTEG_GAIN  = 32'sd0;
    localparam logic signed [DATA_W-1:0]    RST_DERIV_GAIN  = 32'sd0;
    localparam logic        [DIVISOR_W-1:0] RST_DIVISOR     = 31'd1;
    localparam logic signed [DATA_W-1:0]    RST_INTEG_LOWER = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0]    RST_INTEG_UPPER = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0]    RST_OUT_LOWER   = -32'sd10000;
    localparam logic signed [DATA_W-1:0]    RST_OUT_UPPER   = 32'sd10000;

    localparam logic [0:0] OP_UPDATE = 1'b0;
    localparam logic [0:0] OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0]    prop_gain;
        logic signed [DATA_W-1:0]    integ_gain;
        logic signed [DATA_W-1:0]    deriv_gain;
        logic        [DIVISOR_W-1:0] divisor;
        logic signed [DATA_W-1:0]    integ_min;
        logic signed [DATA_W-1:0]    integ_max;
        logic signed [DATA_W-1:0]    out_min;
        logic signed [DATA_W-1:0]    out_max;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERROR,
        ST_INTEG,
        ST_MUL_PROP,
        ST_MUL_INTEG,
        ST_MUL_DERIV,
        ST_MUL_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     take_error;
        logic     take_integ;
        mul_sel_t mul_sel;
        logic     acc_clear;
        logic     acc_add;
        logic     div_start;
        logic     out_load;
    } ctrl_t;

    typedef struct packed {
        logic done;
    } div_status_t;

endpackage

[src/ipsc_if.sv]
// request and result channel interfaces
interface ipsc_sample_if;
    import ipsc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [DATA_W-1:0] target_speed;
    logic signed [DATA_W-1:0] measured_speed;

    modport source (output valid, output operation, output target_speed,
                    output measured_speed, input ready);
    modport sink   (input valid, input operation, input target_speed,
                    input measured_speed, output ready);
endinterface

interface ipsc_result_if;
    import ipsc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] echo_target;
    logic signed [DATA_W-1:0] echo_measured;
    logic signed [DATA_W-1:0] error_value;
    logic signed [DATA_W-1:0] integral_value;
    logic signed [DATA_W-1:0] drive_output;

    modport source (output valid, output echo_target, output echo_measured,
                    output error_value, output integral_value, output drive_output,
                    input ready);
    modport sink   (input valid, input echo_target, input echo_measured,
                    input error_value, input integral_value, input drive_output,
                    output ready);
endinterface

[src/integer_pid_speed_control.sv]
// top level: sequencer and datapath of the integer pid speed controller
//
// Requests arrive on the sample channel (valid/ready). An update request forms
// the saturated error, the clamped integral and the derivative, runs three
// products through one shared multiplier into a wide accumulator, then divides
// the magnitude by the configured divisor in a serial divider, one bit a cycle.
// A result leaves on the result channel after the 66-step divider finishes and
// the result register is free; a new update request is taken only once the
// previous update is done. A clear request zeroes integral and previous error
// and gives no result. Ready is high only while the sequencer is idle.
// The result register holds its item until the receiver takes it; a new
// request is accepted meanwhile, and a finished update waits in its last step
// while that register is still full. Configuration is written through
// cfg_we/cfg_index/cfg_wdata, by the user only while the block is idle; the
// block itself does not enforce this. Reset clears the state, the sequencer
// and result valid, and loads the register defaults.
module integer_pid_speed_control
    import ipsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ipsc_sample_if.sink            sample,
    ipsc_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_wdata
);

    cfg_t        cfg;
    ctrl_t       ctrl;
    div_status_t div_stat;
    state_t      state_reg, state_next;

    logic signed [DATA_W-1:0]    target_reg, measured_reg;
    logic signed [DATA_W-1:0]    error_reg, integ_reg, last_reg;
    logic signed [OPERAND_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [OPERAND_W-1:0] op_a, op_b;
    logic signed [PRODUCT_W-1:0] product;
    logic [DIVIDEND_W-1:0]       quotient;
    logic [DIVIDEND_W-1:0]       acc_mag;

    logic                        out_valid_reg;
    logic signed [DATA_W-1:0]    out_target_reg, out_measured_reg, out_error_reg;
    logic signed [DATA_W-1:0]    out_integ_reg, out_drive_reg;

    logic                        accept;
    logic                        out_free;
    logic signed [OPERAND_W-1:0] diff;
    logic signed [DATA_W-1:0]    error_next;
    logic signed [OPERAND_W-1:0] integ_sum;
    logic signed [DATA_W-1:0]    integ_next;
    logic                        q_over;
    logic [DATA_W:0]             q_mag;
    logic signed [DATA_W+1:0]    drive_wide;
    logic signed [DATA_W-1:0]    drive_next;

    ipsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipsc_mul u_mul (
        .clk         (clk),
        .op_a        (op_a),
        .op_b        (op_b),
        .product_reg (product)
    );

    ipsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (acc_mag),
        .divisor  (cfg.divisor),
        .status   (div_stat),
        .quotient (quotient)
    );

    assign accept   = sample.valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid && sample.operation == OP_UPDATE)
                begin
                    state_next = ST_ERROR;
                end
            end
            ST_ERROR:     state_next = ST_INTEG;
            ST_INTEG:     state_next = ST_MUL_PROP;
            ST_MUL_PROP:  state_next = ST_MUL_INTEG;
            ST_MUL_INTEG: state_next = ST_MUL_DERIV;
            ST_MUL_DERIV: state_next = ST_MUL_SUM;
            ST_MUL_SUM:   state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl = '{in_ready: 1'b0, take_error: 1'b0, take_integ: 1'b0, mul_sel: MUL_PROP,
                 acc_clear: 1'b0, acc_add: 1'b0, div_start: 1'b0, out_load: 1'b0};
        case (state_reg)
            ST_IDLE:      ctrl.in_ready   = 1'b1;
            ST_ERROR:     ctrl.take_error = 1'b1;
            ST_INTEG:     ctrl.take_integ = 1'b1;
            ST_MUL_PROP:
            begin
                ctrl.mul_sel   = MUL_PROP;
                ctrl.acc_clear = 1'b1;
            end
            ST_MUL_INTEG:
            begin
                ctrl.mul_sel = MUL_INTEG;
                ctrl.acc_add = 1'b1;
            end
            ST_MUL_DERIV:
            begin
                ctrl.mul_sel = MUL_DERIV;
                ctrl.acc_add = 1'b1;
            end
            ST_MUL_SUM:   ctrl.acc_add   = 1'b1;
            ST_DIV_START: ctrl.div_start = 1'b1;
            ST_DIV_WAIT:  ;
            ST_FINISH:    ctrl.out_load  = out_free;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // error, saturated to 32 bits
    assign diff       = {target_reg[DATA_W-1], target_reg}
                      - {measured_reg[DATA_W-1], measured_reg};
    assign error_next = (diff[DATA_W] != diff[DATA_W-1])
                      ? {diff[DATA_W], {(DATA_W-1){~diff[DATA_W]}}}
                      : diff[DATA_W-1:0];

    // integral with clamp
    assign integ_sum = {integ_reg[DATA_W-1], integ_reg} + {error_reg[DATA_W-1], error_reg};

    always_comb
    begin
        if (integ_sum < $signed({cfg.integ_min[DATA_W-1], cfg.integ_min}))
        begin
            integ_next = cfg.integ_min;
        end
        else if (integ_sum > $signed({cfg.integ_max[DATA_W-1], cfg.integ_max}))
        begin
            integ_next = cfg.integ_max;
        end
        else
        begin
            integ_next = integ_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            last_reg  <= '0;
        end
        else if (accept && sample.operation == OP_CLEAR)
        begin
            integ_reg <= '0;
            last_reg  <= '0;
        end
        else if (ctrl.take_integ)
        begin
            integ_reg <= integ_next;
            last_reg  <= error_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg   <= sample.target_speed;
            measured_reg <= sample.measured_speed;
        end
        if (ctrl.take_error)
        begin
            error_reg <= error_next;
        end
        if (ctrl.take_integ)
        begin
            deriv_reg <= {error_reg[DATA_W-1], error_reg} - {last_reg[DATA_W-1], last_reg};
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_PROP:
            begin
                op_a = {cfg.prop_gain[DATA_W-1], cfg.prop_gain};
                op_b = {error_reg[DATA_W-1], error_reg};
            end
            MUL_INTEG:
            begin
                op_a = {cfg.integ_gain[DATA_W-1], cfg.integ_gain};
                op_b = {integ_reg[DATA_W-1], integ_reg};
            end
            MUL_DERIV:
            begin
                op_a = {cfg.deriv_gain[DATA_W-1], cfg.deriv_gain};
                op_b = deriv_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + {product[PRODUCT_W-1], product};
        end
    end

    assign acc_mag = acc_reg[ACC_W-1] ? DIVIDEND_W'(~acc_reg + ACC_W'(1))
                                      : acc_reg[DIVIDEND_W-1:0];

    // signed quotient, saturated past 32 bits, then output clamp
    assign q_over     = |quotient[DIVIDEND_W-1:DATA_W];
    assign q_mag      = q_over ? {1'b1, {DATA_W{1'b0}}} : {1'b0, quotient[DATA_W-1:0]};
    assign drive_wide = acc_reg[ACC_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    always_comb
    begin
        if (drive_wide < $signed({{2{cfg.out_min[DATA_W-1]}}, cfg.out_min}))
        begin
            drive_next = cfg.out_min;
        end
        else if (drive_wide > $signed({{2{cfg.out_max[DATA_W-1]}}, cfg.out_max}))
        begin
            drive_next = cfg.out_max;
        end
        else
        begin
            drive_next = drive_wide[DATA_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_target_reg   <= target_reg;
            out_measured_reg <= measured_reg;
            out_error_reg    <= error_reg;
            out_integ_reg    <= integ_reg;
            out_drive_reg    <= drive_next;
        end
    end

    assign sample.ready          = ctrl.in_ready;
    assign result.valid          = out_valid_reg;
    assign result.echo_target    = out_target_reg;
    assign result.echo_measured  = out_measured_reg;
    assign result.error_value    = out_error_reg;
    assign result.integral_value = out_integ_reg;
    assign result.drive_output   = out_drive_reg;

endmodule

[src/ipsc_cfg_regs.sv]
// configuration register file with bound ordering
module ipsc_cfg_regs
    import ipsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_wdata,
    output cfg_t                   cfg
);

    logic signed [DATA_W-1:0]    prop_reg;
    logic signed [DATA_W-1:0]    integ_reg;
    logic signed [DATA_W-1:0]    deriv_reg;
    logic        [DIVISOR_W-1:0] div_reg;
    logic signed [DATA_W-1:0]    ilo_reg;
    logic signed [DATA_W-1:0]    ihi_reg;
    logic signed [DATA_W-1:0]    olo_reg;
    logic signed [DATA_W-1:0]    ohi_reg;
    logic        [DIVISOR_W-1:0] div_wdata;

    assign div_wdata = (cfg_wdata[DIVISOR_W-1:0] == '0) ? DIVISOR_W'(1)
                                                       : cfg_wdata[DIVISOR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_reg  <= RST_PROP_GAIN;
            integ_reg <= RST_INTEG_GAIN;
            deriv_reg <= RST_DERIV_GAIN;
            div_reg   <= RST_DIVISOR;
            ilo_reg   <= RST_INTEG_LOWER;
            ihi_reg   <= RST_INTEG_UPPER;
            olo_reg   <= RST_OUT_LOWER;
            ohi_reg   <= RST_OUT_UPPER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_reg  <= cfg_wdata;
                REG_INTEG_GAIN:  integ_reg <= cfg_wdata;
                REG_DERIV_GAIN:  deriv_reg <= cfg_wdata;
                REG_DIVISOR:     div_reg   <= div_wdata;
                REG_INTEG_LOWER: ilo_reg   <= cfg_wdata;
                REG_INTEG_UPPER: ihi_reg   <= cfg_wdata;
                REG_OUT_LOWER:   olo_reg   <= cfg_wdata;
                REG_OUT_UPPER:   ohi_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // swapped bounds behave as ordered
    always_comb
    begin
        cfg.prop_gain  = prop_reg;
        cfg.integ_gain = integ_reg;
        cfg.deriv_gain = deriv_reg;
        cfg.divisor    = div_reg;
        cfg.integ_min  = (ilo_reg < ihi_reg) ? ilo_reg : ihi_reg;
        cfg.integ_max  = (ilo_reg < ihi_reg) ? ihi_reg : ilo_reg;
        cfg.out_min    = (olo_reg < ohi_reg) ? olo_reg : ohi_reg;
        cfg.out_max    = (olo_reg < ohi_reg) ? ohi_reg : olo_reg;
    end

endmodule

[src/ipsc_mul.sv]
// shared signed multiplier with registered product
module ipsc_mul
    import ipsc_pkg::*;
(
    input  logic                        clk,
    input  logic signed [OPERAND_W-1:0] op_a,
    input  logic signed [OPERAND_W-1:0] op_b,
    output logic signed [PRODUCT_W-1:0] product_reg
);

    logic signed [PRODUCT_W-1:0] product_next;

    assign product_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

endmodule

[src/ipsc_div.sv]
// serial restoring divider, one quotient bit per cycle
module ipsc_div
    import ipsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

[test/integer_pid_speed_control_tb.sv]
`timescale 1ns / 100ps
// testbench of the integer pid speed controller: directed and random requests against a predictor
module integer_pid_speed_control_tb;
    import ipsc_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 135;
    localparam int ITEMS_PER_SETTING = 45;

    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] integ;
        logic signed [DATA_W-1:0] drive;
    } pid_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_wdata;

    ipsc_sample_if sample ();
    ipsc_result_if result ();

    integer_pid_speed_control i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of settings and loop state
    logic signed [DATA_W-1:0]    prop_gain;
    logic signed [DATA_W-1:0]    integ_gain;
    logic signed [DATA_W-1:0]    deriv_gain;
    logic        [DIVISOR_W-1:0] divisor;
    logic signed [DATA_W-1:0]    integ_lo;
    logic signed [DATA_W-1:0]    integ_hi;
    logic signed [DATA_W-1:0]    out_lo;
    logic signed [DATA_W-1:0]    out_hi;
    logic signed [DATA_W-1:0]    integ_state;
    logic signed [DATA_W-1:0]    prev_error;

    pid_result_t pending_results[$];
    pid_result_t oldest_result;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [127:0] clamp_wide(input logic signed [127:0] v,
                                                       input logic signed [127:0] a,
                                                       input logic signed [127:0] b);
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic reset_model();
        prop_gain   = RST_PROP_GAIN;
        integ_gain  = RST_INTEG_GAIN;
        deriv_gain  = RST_DERIV_GAIN;
        divisor     = RST_DIVISOR;
        integ_lo    = RST_INTEG_LOWER;
        integ_hi    = RST_INTEG_UPPER;
        out_lo      = RST_OUT_LOWER;
        out_hi      = RST_OUT_UPPER;
        integ_state = '0;
        prev_error  = '0;
    endtask

    task automatic compute_pid_step(input logic op, input logic signed [DATA_W-1:0] tgt,
                                    input logic signed [DATA_W-1:0] meas);
        logic signed [127:0] tgt_w;
        logic signed [127:0] meas_w;
        logic signed [127:0] state_w;
        logic signed [127:0] prev_w;
        logic signed [127:0] err_w;
        logic signed [127:0] integ_w;
        logic signed [127:0] deriv_w;
        logic signed [127:0] kp_w;
        logic signed [127:0] ki_w;
        logic signed [127:0] kd_w;
        logic signed [127:0] div_w;
        logic signed [127:0] sum_w;
        logic signed [127:0] drive_w;
        pid_result_t         res;
        if (op == OP_CLEAR)
        begin
            integ_state = '0;
            prev_error  = '0;
        end
        else
        begin
            tgt_w   = tgt;
            meas_w  = meas;
            state_w = integ_state;
            prev_w  = prev_error;
            kp_w    = prop_gain;
            ki_w    = integ_gain;
            kd_w    = deriv_gain;
            div_w   = {97'd0, divisor};
            err_w   = clamp_wide(tgt_w - meas_w, S32_MIN, S32_MAX);
            integ_w = clamp_wide(state_w + err_w, integ_lo, integ_hi);
            deriv_w = err_w - prev_w;
            sum_w   = kp_w * err_w + ki_w * integ_w + kd_w * deriv_w;
            // signed division truncates toward zero
            drive_w = clamp_wide(sum_w / div_w, out_lo, out_hi);
            integ_state = integ_w[DATA_W-1:0];
            prev_error  = err_w[DATA_W-1:0];
            res.tgt   = tgt;
            res.meas  = meas;
            res.err   = err_w[DATA_W-1:0];
            res.integ = integ_w[DATA_W-1:0];
            res.drive = drive_w[DATA_W-1:0];
            pending_results.push_back(res);
        end
    endtask

    task automatic send_request(input logic op, input logic signed [DATA_W-1:0] tgt,
                                input logic signed [DATA_W-1:0] meas);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(negedge clk);
        end
        sample.valid          <= 1'b1;
        sample.operation      <= op;
        sample.target_speed   <= tgt;
        sample.measured_speed <= meas;
        do
            @(posedge clk);
        while (!sample.ready);
        compute_pid_step(op, tgt, meas);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_PROP_GAIN:   prop_gain  = value;
            REG_INTEG_GAIN:  integ_gain = value;
            REG_DERIV_GAIN:  deriv_gain = value;
            REG_DIVISOR:     divisor    = (value[DIVISOR_W-1:0] == '0) ? 31'd1
                                                                       : value[DIVISOR_W-1:0];
            REG_INTEG_LOWER: integ_lo   = value;
            REG_INTEG_UPPER: integ_hi   = value;
            REG_OUT_LOWER:   out_lo     = value;
            REG_OUT_UPPER:   out_hi     = value;
            default:         ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void check_field(input string name, input logic signed [DATA_W-1:0] want,
                                        input logic signed [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("drive_output: expected no result, got %0d", result.drive_output);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("echo_target", oldest_result.tgt, result.echo_target);
                check_field("echo_measured", oldest_result.meas, result.echo_measured);
                check_field("error_value", oldest_result.err, result.error_value);
                check_field("integral_value", oldest_result.integ, result.integral_value);
                check_field("drive_output", oldest_result.drive, result.drive_output);
            end
        end
    end

    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= sink_idle_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] rand_speed();
        case ($urandom_range(9))
            0:          return S32_MAX;
            1:          return S32_MIN;
            2, 3, 4, 5: return $signed($urandom_range(0, 20000)) - 32'sd10000;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(7))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3, 4, 5: return $signed($urandom_range(0, 200)) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_bound();
        case ($urandom_range(7))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2, 3, 4: return $signed($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_divisor();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'd1;
            4, 5, 6: return $urandom_range(1, 1000);
            default: return ($urandom & 32'h7fff_ffff) >> $urandom_range(0, 30);
        endcase
    endfunction

    task automatic randomize_settings();
        write_reg(REG_PROP_GAIN, rand_gain());
        write_reg(REG_INTEG_GAIN, rand_gain());
        write_reg(REG_DERIV_GAIN, rand_gain());
        write_reg(REG_DIVISOR, rand_divisor());
        write_reg(REG_INTEG_LOWER, rand_bound());
        write_reg(REG_INTEG_UPPER, rand_bound());
        write_reg(REG_OUT_LOWER, rand_bound());
        write_reg(REG_OUT_UPPER, rand_bound());
    endtask

    task automatic test_default_settings();
        send_request(OP_UPDATE, 32'sd0, 32'sd0);
        send_request(OP_UPDATE, 32'sd1234, 32'sd1000);
        send_request(OP_UPDATE, 32'sd50000, 32'sd0);
        send_request(OP_UPDATE, -32'sd50000, 32'sd0);
        send_request(OP_CLEAR, $urandom, $urandom);
    endtask

    task automatic test_error_saturation();
        send_request(OP_UPDATE, S32_MAX, S32_MIN);
        send_request(OP_UPDATE, S32_MAX, -32'sd1);
        send_request(OP_UPDATE, S32_MIN, S32_MAX);
        send_request(OP_UPDATE, S32_MIN, 32'sd1);
        send_request(OP_UPDATE, S32_MIN, S32_MIN);
    endtask

    task automatic test_integral_clamp();
        wait_idle();
        // swapped integral and output bounds
        write_reg(REG_PROP_GAIN, 32'd0);
        write_reg(REG_INTEG_GAIN, 32'd1);
        write_reg(REG_INTEG_LOWER, 32'd100);
        write_reg(REG_INTEG_UPPER, -32'sd50);
        write_reg(REG_OUT_LOWER, S32_MAX);
        write_reg(REG_OUT_UPPER, S32_MIN);
        send_request(OP_CLEAR, 32'sd0, 32'sd0);
        send_request(OP_UPDATE, 32'sd1000, 32'sd0);
        send_request(OP_UPDATE, -32'sd1000, 32'sd0);
        send_request(OP_UPDATE, 32'sd10, 32'sd0);
        send_request(OP_CLEAR, 32'sd0, 32'sd0);
        send_request(OP_UPDATE, -32'sd10, -32'sd30);
    endtask

    task automatic test_divisor_rounding();
        wait_idle();
        write_reg(REG_PROP_GAIN, 32'd1);
        write_reg(REG_INTEG_GAIN, 32'd0);
        write_reg(REG_DIVISOR, 32'd3);
        send_request(OP_UPDATE, -32'sd7, 32'sd0);
        send_request(OP_UPDATE, 32'sd7, 32'sd0);
        wait_idle();
        write_reg(REG_DIVISOR, 32'd0);
        send_request(OP_UPDATE, 32'sd5, 32'sd0);
        wait_idle();
        write_reg(REG_DIVISOR, 32'h8000_0000);
        send_request(OP_UPDATE, -32'sd5, 32'sd0);
        wait_idle();
        write_reg(REG_DIVISOR, 32'h7fff_ffff);
        send_request(OP_UPDATE, S32_MAX, S32_MIN);
        send_request(OP_UPDATE, S32_MIN, 32'sd0);
    endtask

    task automatic test_extreme_gains();
        wait_idle();
        write_reg(REG_PROP_GAIN, S32_MIN);
        write_reg(REG_INTEG_GAIN, S32_MIN);
        write_reg(REG_DERIV_GAIN, S32_MIN);
        write_reg(REG_DIVISOR, 32'd1);
        write_reg(REG_INTEG_LOWER, S32_MIN);
        write_reg(REG_INTEG_UPPER, S32_MAX);
        write_reg(REG_OUT_LOWER, S32_MIN);
        write_reg(REG_OUT_UPPER, S32_MAX);
        send_request(OP_CLEAR, 32'sd0, 32'sd0);
        send_request(OP_UPDATE, S32_MAX, S32_MIN);
        send_request(OP_UPDATE, S32_MIN, S32_MAX);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        logic                     op;
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        wait_idle();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n % ITEMS_PER_SETTING == 0)
            begin
                wait_idle();
                randomize_settings();
            end
            op  = ($urandom_range(99) < 8) ? OP_CLEAR : OP_UPDATE;
            tgt = rand_speed();
            // often track near the setpoint
            if ($urandom_range(99) < 40)
                meas = tgt - ($signed($urandom_range(0, 2000)) - 32'sd1000);
            else
                meas = rand_speed();
            send_request(op, tgt, meas);
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        sample.valid          = 1'b0;
        sample.operation      = OP_UPDATE;
        sample.target_speed   = '0;
        sample.measured_speed = '0;
        result.ready          = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_PROP_GAIN;
        cfg_wdata             = '0;
        reset_model();
        src_idle_pct  = 29;
        sink_idle_pct = 46;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_settings();
        test_error_saturation();
        test_integral_clamp();
        test_divisor_rounding();
        test_extreme_gains();
        test_random_traffic(29, 46);
        test_random_traffic(46, 29);
        test_random_traffic(0, 0);
        wait_idle();

        if (pending_results.size() != 0)
        begin
            $error("drive_output: expected %0d, got no result", pending_results[0].drive);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
